@@ design/stable_rank_sorter_defines.svh @@
// ----------------------------------------------------------------------------
// stable_rank_sorter assertion macros
// Shared property forms for the sorter checker.
// ----------------------------------------------------------------------------
`ifndef STABLE_RANK_SORTER_DEFINES_SVH
`define STABLE_RANK_SORTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SRS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stable_rank_sorter: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define SRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stable_rank_sorter: next-cycle check failed");

`endif

@@ design/srs_pkg.sv @@
// ----------------------------------------------------------------------------
// srs_pkg
// Types and fixed widths shared by the stable rank sorter modules.
// ----------------------------------------------------------------------------
package srs_pkg;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;

    typedef struct packed {
        logic [VALUE_W-1:0] sample_value;
        logic               final_sample;
    } sample_t;

    typedef struct packed {
        logic [INDEX_W-1:0] ranked_index;
        logic               final_rank;
        logic               overflow_flag;
    } rank_t;

    // Contents of one cell of the chain
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
    } cell_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic               insert;
        logic               shift_out;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
    } cell_cmd_t;

endpackage

@@ design/srs_cell.sv @@
// ----------------------------------------------------------------------------
// srs_cell
// One slot of the insertion chain: holds a value and its arrival index.
// ----------------------------------------------------------------------------
module srs_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  srs_pkg::cell_cmd_t cmd,
    input  srs_pkg::cell_t    prev_cell,
    input  logic              prev_le,
    input  srs_pkg::cell_t    next_cell,
    output srs_pkg::cell_t    cell_q,
    output logic              le
);
    import srs_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic [INDEX_W-1:0] index_reg;
    logic [INDEX_W-1:0] index_next;

    // Entries that are less than or equal stay put, so ties keep arrival order
    assign le = valid_reg && (value_reg <= cmd.value);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        index_next = index_reg;
        if (cmd.insert && !le)
        begin
            if (prev_le)
            begin
                // first slot past the smaller or equal entries: take the new value
                valid_next = 1'b1;
                value_next = cmd.value;
                index_next = cmd.index;
            end
            else
            begin
                // open the gap: take the neighbor's entry
                valid_next = prev_cell.valid;
                value_next = prev_cell.value;
                index_next = prev_cell.index;
            end
        end
        else if (cmd.shift_out)
        begin
            valid_next = next_cell.valid;
            value_next = next_cell.value;
            index_next = next_cell.index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        index_reg <= index_next;
    end

    assign cell_q.valid = valid_reg;
    assign cell_q.value = value_reg;
    assign cell_q.index = index_reg;

endmodule

@@ design/stable_rank_sorter.sv @@
// ----------------------------------------------------------------------------
// stable_rank_sorter
// Stable argsort of a stream of unsigned 32-bit values by an insertion chain.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel: sample_valid / sample_stall / sample. One value per
//   transfer; final_sample marks the last value of a data set.
//   rank channel: rank_valid / rank_stall / rank. After the final value the
//   block emits the arrival indices in ascending order of value (equal values
//   in arrival order), final_rank on the last, overflow_flag on each if
//   values beyond MAX_ITEMS were dropped.
// Timing:
//   Loading: every cell compares against the new value in parallel and the
//   chain opens a gap for it in the same cycle.
//   The first result is valid the cycle after the final value transfers;
//   the chain then shifts one entry toward the output per rank transfer.
//   sample_stall is high from the final transfer until the last result
//   transfers.
// Reset: all cells empty, count and drop mark cleared, ready to load.
// Stall: a stalled result holds in the head cell and the chain waits.
// ----------------------------------------------------------------------------
module stable_rank_sorter #(
    parameter int MAX_ITEMS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  srs_pkg::sample_t sample,
    output logic             rank_valid,
    input  logic             rank_stall,
    output srs_pkg::rank_t   rank
);
    import srs_pkg::*;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    state_t             state_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               dropped_reg;

    cell_cmd_t cmd;
    cell_t     cells [MAX_ITEMS];
    cell_t     prevs [MAX_ITEMS];
    cell_t     nexts [MAX_ITEMS];
    logic      les   [MAX_ITEMS];
    logic      prev_les [MAX_ITEMS];

    logic sample_xfer;
    logic rank_xfer;
    logic has_room;

    assign sample_stall = (state_reg == ST_DRAIN);
    assign sample_xfer  = sample_valid && !sample_stall;
    assign rank_valid   = (state_reg == ST_DRAIN) && cells[0].valid;
    assign rank_xfer    = rank_valid && !rank_stall;
    assign has_room     = count_reg < COUNT_W'(MAX_ITEMS);

    assign cmd.insert    = sample_xfer && has_room;
    assign cmd.shift_out = rank_xfer;
    assign cmd.value     = sample.sample_value;
    assign cmd.index     = count_reg[INDEX_W-1:0];

    genvar i;
    generate
        for (i = 0; i < MAX_ITEMS; i++)
        begin : g_chain
            if (i == 0)
            begin : g_head
                assign prevs[i]    = '0;
                assign prev_les[i] = 1'b1;
            end
            else
            begin : g_body
                assign prevs[i]    = cells[i-1];
                assign prev_les[i] = les[i-1];
            end
            if (i == MAX_ITEMS - 1)
            begin : g_tail
                assign nexts[i] = '0;
            end
            else
            begin : g_link
                assign nexts[i] = cells[i+1];
            end

            srs_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .prev_cell (prevs[i]),
                .prev_le   (prev_les[i]),
                .next_cell (nexts[i]),
                .cell_q    (cells[i]),
                .le        (les[i])
            );
        end
    endgenerate

    assign rank.ranked_index  = cells[0].index;
    assign rank.final_rank    = !nexts[0].valid;
    assign rank.overflow_flag = dropped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_LOAD:
                begin
                    if (sample_xfer)
                    begin
                        if (has_room)
                        begin
                            count_reg <= count_reg + COUNT_W'(1);
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                        if (sample.final_sample)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN:
                begin
                    // last result gone: clear for the next data set
                    if (rank_xfer && rank.final_rank)
                    begin
                        state_reg   <= ST_LOAD;
                        count_reg   <= '0;
                        dropped_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

@@ design/srs_checker.sv @@
// ----------------------------------------------------------------------------
// srs_checker
// Port-level checks for the stable rank sorter, bound to the top level.
// ----------------------------------------------------------------------------
`include "stable_rank_sorter_defines.svh"

module srs_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             sample_valid,
    input logic             sample_stall,
    input srs_pkg::sample_t sample,
    input logic             rank_valid,
    input logic             rank_stall,
    input srs_pkg::rank_t   rank
);
    import srs_pkg::*;

    logic final_xfer;
    logic last_rank_xfer;

    assign final_xfer     = sample_valid && !sample_stall && sample.final_sample;
    assign last_rank_xfer = rank_valid && !rank_stall && rank.final_rank;

    // No new value is taken while a ranking is being emitted
    `SRS_ASSERT_IMP(a_stall_while_emit, rank_valid, sample_stall)

    // The ranking starts right after the final value transfers
    `SRS_ASSERT_NEXT(a_emit_after_final, final_xfer, rank_valid)

    // Nothing follows the last index of a ranking
    `SRS_ASSERT_NEXT(a_end_after_final, last_rank_xfer, !rank_valid)

    // A stalled result holds
    `SRS_ASSERT_NEXT(a_rank_hold, rank_valid && rank_stall, rank_valid && $stable(rank))

endmodule

bind stable_rank_sorter srs_checker u_srs_checker (.*);

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stable_rank_sorter. A stable insertion ranking
// predicts the index stream of every data set. A short table of hand-picked
// samples comes first. Random data sets follow in three phases of sender and
// receiver idling, with full, just-over and far-over capacity sets included.
// Every rank transfer is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import srs_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int CAPACITY       = 64;
    localparam int PHASE_ITEMS    = 130;
    localparam int DRAIN_CYCLES   = 16;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int N_ROWS         = 21;

    typedef struct packed {
        sample_t item;
        logic    typed;
        rank_t   want;
    } stim_row_t;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    sample_valid = 1'b0;
    logic    sample_stall;
    sample_t sample       = '0;
    logic    rank_valid;
    logic    rank_stall   = 1'b0;
    rank_t   rank;

    // Predictor state: kept values and their stable ranking
    logic [VALUE_W-1:0] held_values [CAPACITY];
    logic [INDEX_W-1:0] rank_order  [CAPACITY];
    int                 held_count  = 0;
    logic               overflowed  = 1'b0;

    rank_t expected_ranks [$];
    int    error_count    = 0;
    int    result_count   = 0;
    int    send_idle_pct  = 0;
    int    recv_idle_pct  = 0;

    stable_rank_sorter #(
        .MAX_ITEMS(CAPACITY)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample      (sample),
        .rank_valid  (rank_valid),
        .rank_stall  (rank_stall),
        .rank        (rank)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // Take one sample into the ranking; on a final sample emit the whole order
    function automatic int rank_sample(input sample_t item, output rank_t ranks [CAPACITY]);
        int pos;
        int n;
        if (held_count < CAPACITY)
        begin
            pos = 0;
            while (pos < held_count && held_values[rank_order[pos]] <= item.sample_value)
                pos++;
            for (int k = held_count; k > pos; k--)
                rank_order[k] = rank_order[k - 1];
            rank_order[pos] = INDEX_W'(held_count);
            held_values[held_count] = item.sample_value;
            held_count++;
        end
        else
            overflowed = 1'b1;
        if (!item.final_sample)
            return 0;
        for (int k = 0; k < held_count; k++)
            ranks[k] = '{rank_order[k], (k == held_count - 1), overflowed};
        n = held_count;
        held_count = 0;
        overflowed = 1'b0;
        return n;
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 7);
            2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            default: return 32'hFFFF_FFF8 | $urandom_range(0, 7);
        endcase
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        if (error_count < 100)
            $display("mismatch at result %0d: %s got %0d, want %0d",
                     result_count, field, got, want);
        error_count++;
    endtask

    // Enter at a falling edge; leave at the falling edge after the transfer
    task automatic send_sample(input sample_t item, input logic typed, input rank_t want);
        rank_t ranks [CAPACITY];
        int    n;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample       <= item;
        sample_valid <= 1'b1;
        do
            @(posedge clk);
        while (sample_stall);
        n = rank_sample(item, ranks);
        if (typed)
            expected_ranks.push_back(want);
        else
            for (int k = 0; k < n; k++)
                expected_ranks.push_back(ranks[k]);
        @(negedge clk);
    endtask

    // Drop valid, then hold off until every ranking has drained
    task automatic drain_rankings();
        sample_valid <= 1'b0;
        @(negedge clk);
        while (expected_ranks.size() != 0)
            @(negedge clk);
    endtask

    always @(negedge clk)
        rank_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    always @(posedge clk)
    begin
        rank_t want;
        if (rst_n && rank_valid && !rank_stall)
        begin
            if (expected_ranks.size() == 0)
                report_mismatch("unexpected ranked_index", rank.ranked_index, -1);
            else
            begin
                want = expected_ranks.pop_front();
                if (rank.ranked_index !== want.ranked_index)
                    report_mismatch("ranked_index", rank.ranked_index, want.ranked_index);
                if (rank.final_rank !== want.final_rank)
                    report_mismatch("final_rank", rank.final_rank, want.final_rank);
                if (rank.overflow_flag !== want.overflow_flag)
                    report_mismatch("overflow_flag", rank.overflow_flag, want.overflow_flag);
            end
            result_count++;
        end
    end

    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        stim_row_t rows [N_ROWS];
        int        sent;
        int        len;
        int        forced_len;
        logic      first;

        // Single-value sets can be read off directly; the rest go to the predictor
        rows = '{
            '{'{32'h0000_0000, 1'b1}, 1'b1, '{6'd0, 1'b1, 1'b0}},
            '{'{32'hFFFF_FFFF, 1'b1}, 1'b1, '{6'd0, 1'b1, 1'b0}},
            '{'{32'h0000_0007, 1'b0}, 1'b0, '0},
            '{'{32'h0000_0007, 1'b0}, 1'b0, '0},
            '{'{32'h0000_0007, 1'b1}, 1'b0, '0},
            '{'{32'hFFFF_FFFF, 1'b0}, 1'b0, '0},
            '{'{32'h8000_0000, 1'b0}, 1'b0, '0},
            '{'{32'h0000_0001, 1'b0}, 1'b0, '0},
            '{'{32'h0000_0000, 1'b1}, 1'b0, '0},
            '{'{32'h0000_0000, 1'b0}, 1'b0, '0},
            '{'{32'hFFFF_FFFF, 1'b0}, 1'b0, '0},
            '{'{32'h0000_0000, 1'b1}, 1'b0, '0},
            '{'{32'h0000_0005, 1'b0}, 1'b0, '0},
            '{'{32'h0000_0003, 1'b0}, 1'b0, '0},
            '{'{32'h0000_0005, 1'b0}, 1'b0, '0},
            '{'{32'h0000_0003, 1'b0}, 1'b0, '0},
            '{'{32'h0000_0004, 1'b1}, 1'b0, '0},
            '{'{32'hAAAA_AAAA, 1'b0}, 1'b0, '0},
            '{'{32'h5555_5555, 1'b0}, 1'b0, '0},
            '{'{32'hAAAA_AAAA, 1'b1}, 1'b0, '0},
            '{'{32'h1234_5678, 1'b1}, 1'b1, '{6'd0, 1'b1, 1'b0}}
        };

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 26;
        recv_idle_pct = 88;
        for (int r = 0; r < N_ROWS; r++)
            send_sample(rows[r].item, rows[r].typed, rows[r].want);
        drain_rankings();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 26;
                    recv_idle_pct = 88;
                    forced_len    = CAPACITY;
                end
                1:
                begin
                    send_idle_pct = 88;
                    recv_idle_pct = 26;
                    forced_len    = CAPACITY + 1;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    forced_len    = CAPACITY + 6;
                end
            endcase
            sent  = 0;
            first = 1'b1;
            while (sent < PHASE_ITEMS)
            begin
                // Open each phase at or past capacity, then mostly short sets
                if (first)
                    len = forced_len;
                else if ($urandom_range(0, 99) < 8)
                    len = $urandom_range(20, CAPACITY);
                else
                    len = $urandom_range(1, 8);
                first = 1'b0;
                for (int j = 0; j < len; j++)
                    send_sample('{random_value(), (j == len - 1)}, 1'b0, '0);
                sent += len;
            end
            drain_rankings();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0 && expected_ranks.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
